// ===== rtl/csps_pkg.sv =====
// Shared types, codes and helpers of the camera snapshot sequencer.
`timescale 1ns / 1ps
`default_nettype none

package csps_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RETRY_WAIT  = 3'd0,
    REG_IDLE_LIMIT  = 3'd1,
    REG_INIT_PARAMS = 3'd2,
    REG_QUALITY     = 3'd3,
    REG_PICTURE     = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] RetryWaitRst  = 16'd5;
  localparam logic [15:0] IdleLimitRst  = 16'd200;
  localparam logic [31:0] InitParamsRst = 32'h0487_0107;
  localparam logic [7:0]  QualityRst    = 8'h00;
  localparam logic [7:0]  PictureRst    = 8'h05;

  // Depth of the command queue between front and back end (2 or more)
  localparam int unsigned QueueDepth = 4;

  // Camera packet tokens
  localparam logic [7:0] TOK_INITIAL = 8'h01;
  localparam logic [7:0] TOK_GET_PIC = 8'h04;
  localparam logic [7:0] TOK_DATA    = 8'h0A;
  localparam logic [7:0] TOK_SYNC    = 8'h0D;
  localparam logic [7:0] TOK_ACK     = 8'h0E;
  localparam logic [7:0] TOK_QUALITY = 8'h10;
  localparam logic [7:0] PKT_PREFIX  = 8'hFF;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_IMAGE = 2'd1,
    KIND_BAUD  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INIT_REJ    = 3'd1,
    ST_QUALITY_REJ = 3'd2,
    ST_PICTURE_REJ = 3'd3,
    ST_NO_DATA     = 3'd4,
    ST_TIMEOUT     = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] retry_wait;
    logic [15:0] idle_limit;
    logic [31:0] init_params;
    logic [7:0]  quality;
    logic [7:0]  picture;
  } cfg_t;

  // One segment of a command: either a single result or a full 8-byte packet
  typedef struct packed {
    logic        valid;
    logic        is_pkt;
    kind_e       kind;
    status_e     status;
    logic [7:0]  tok;     // token of a packet, or value of a single result
    logic [31:0] params;  // p1 in [31:24] .. p4 in [7:0]
  } seg_t;

  // Everything one transaction causes; seg[1] only follows seg[0]
  typedef struct packed {
    seg_t [1:0] seg;
  } op_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    status_e    status;
    logic       last;
  } res_t;

  function automatic seg_t pkt_seg(input logic [7:0] tok, input logic [31:0] params);
    seg_t s;
    s        = '0;
    s.valid  = 1'b1;
    s.is_pkt = 1'b1;
    s.kind   = KIND_TX;
    s.status = ST_OK;
    s.tok    = tok;
    s.params = params;
    return s;
  endfunction

  function automatic seg_t one_seg(input kind_e kind, input logic [7:0] val,
                                   input status_e st);
    seg_t s;
    s        = '0;
    s.valid  = 1'b1;
    s.is_pkt = 1'b0;
    s.kind   = kind;
    s.status = st;
    s.tok    = val;
    return s;
  endfunction

  function automatic logic [7:0] seg_byte(input seg_t s, input logic [2:0] idx);
    logic [7:0] b;
    b = s.tok;
    if (s.is_pkt) begin
      unique case (idx)
        3'd0, 3'd1, 3'd2: b = PKT_PREFIX;
        3'd3:             b = s.tok;
        3'd4:             b = s.params[31:24];
        3'd5:             b = s.params[23:16];
        3'd6:             b = s.params[15:8];
        3'd7:             b = s.params[7:0];
        default:          b = s.tok;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/csps_if.sv =====
// Valid/ready channel interfaces for sequencer requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface csps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface csps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output kind, output byte_value, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/camera_snapshot_protocol_sequencer.sv =====
// Top level of the camera snapshot sequencer: config registers and datapath.
//
// Usage:
//   item_i   (sink)   transactions carry action (0 start, 1 camera byte, 2 tick)
//                     and rx_byte. Ready drops only while the command queue is full.
//   result_o (source) transactions carry kind, byte_value, status and last; last
//                     marks the final result caused by one input transaction.
//   cfg_*             write-only register port; write it only while the block is idle
//                     (the block does not enforce this): 0 retry wait, 1 idle tick
//                     limit, 2 INITIAL params, 3 quality level, 4 picture type.
// Path: a command is written to the queue at the accepting edge; the back end then
//   loads its first result into the result register.
// Throughput: one input transaction per cycle while the queue has room; the back
//   end emits one result per cycle while result_o is ready, so a transaction
//   holds the output for as many results as it causes (up to 16: ACK + INITIAL).
// Stalls: when result_o is not ready the output register holds; commands pile up
//   in the queue (QUEUE_DEPTH entries) and item_i ready drops once it is full.
// Reset: asynchronous, active low; phase idle, counters and queue cleared, the
//   config registers return to their defaults. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module camera_snapshot_protocol_sequencer import csps_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  csps_in_if.sink             item_i,
  csps_out_if.source          result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  op_t  push_op, head_op;
  logic push, pop, q_full, q_empty;
  res_t res;

  // Config registers; indices past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_wait  <= RetryWaitRst;
      cfg_q.idle_limit  <= IdleLimitRst;
      cfg_q.init_params <= InitParamsRst;
      cfg_q.quality     <= QualityRst;
      cfg_q.picture     <= PictureRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RETRY_WAIT:  cfg_q.retry_wait  <= cfg_wdata_i[15:0];
        REG_IDLE_LIMIT:  cfg_q.idle_limit  <= cfg_wdata_i[15:0];
        REG_INIT_PARAMS: cfg_q.init_params <= cfg_wdata_i;
        REG_QUALITY:     cfg_q.quality     <= cfg_wdata_i[7:0];
        REG_PICTURE:     cfg_q.picture     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Front end: one transaction per cycle while not full; at most one command pushed
  csps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .action_i   (item_i.action),
    .rx_byte_i  (item_i.rx_byte),
    .push_o     (push),
    .op_o       (push_op),
    .q_full_i   (q_full)
  );

  csps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: serializes packets into bytes toward the output register
  csps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (head_op),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .res_o       (res)
  );

  assign result_o.kind       = res.kind;
  assign result_o.byte_value = res.byte_value;
  assign result_o.status     = res.status;
  assign result_o.last       = res.last;

endmodule

`default_nettype wire

// ===== rtl/csps_front.sv =====
// Front end: protocol state machine, packet assembly, command generation.
`timescale 1ns / 1ps
`default_nettype none

module csps_front import csps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output op_t        op_o,
  input  logic       q_full_i
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNCREP,
    PH_RETRY,
    PH_CAMSYNC,
    PH_INITREP,
    PH_QUALREP,
    PH_PICREP,
    PH_DATAHDR,
    PH_IMAGE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [23:0] rem_q, rem_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] wait_q, wait_d;
  // packet bytes 3..6; bytes 0..2 are never inspected, byte 7 comes live
  logic [7:0]  hdr_q [4];
  logic        hdr_we;
  logic [1:0]  hdr_ptr;
  logic        fire;
  logic [23:0] rem_dec;
  logic [15:0] wait_dec;
  op_t         op;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign hdr_ptr    = idx_q[1:0] - 2'd3;
  assign rem_dec    = rem_q - 24'd1;
  assign wait_dec   = (wait_q != 16'd0) ? (wait_q - 16'd1) : wait_q;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    idle_d  = idle_q;
    wait_d  = wait_q;
    hdr_we  = 1'b0;
    op      = '0;
    if (fire) begin
      unique case (action_i)
        ACT_START: begin
          op.seg[0] = pkt_seg(TOK_SYNC, 32'h0);
          idx_d     = 3'd0;
          phase_d   = PH_SYNCREP;
        end
        ACT_BYTE: begin
          if (phase_q == PH_IMAGE) begin
            op.seg[0] = one_seg(KIND_IMAGE, rx_byte_i, ST_OK);
            idle_d    = 16'd0;
            rem_d     = rem_dec;
            if (rem_dec == 24'd0) begin
              op.seg[1] = one_seg(KIND_DONE, 8'h00, ST_OK);
              phase_d   = PH_IDLE;
              idx_d     = 3'd0;
            end
          end else if (phase_q != PH_IDLE && phase_q != PH_RETRY) begin
            if (idx_q != 3'd7) begin
              idx_d  = idx_q + 3'd1;
              hdr_we = (idx_q >= 3'd3) && (idx_q <= 3'd6);
            end else begin
              idx_d = 3'd0;
              unique case (phase_q)
                PH_SYNCREP: begin
                  if (hdr_q[0] == TOK_ACK && hdr_q[1] == TOK_SYNC) begin
                    phase_d = PH_CAMSYNC;
                  end else if (cfg_i.retry_wait == 16'd0) begin
                    op.seg[0] = pkt_seg(TOK_SYNC, 32'h0);
                  end else begin
                    wait_d  = cfg_i.retry_wait;
                    phase_d = PH_RETRY;
                  end
                end
                PH_CAMSYNC: begin
                  if (hdr_q[0] == TOK_SYNC) begin
                    op.seg[0] = pkt_seg(TOK_ACK, {TOK_SYNC, 24'h0});
                    op.seg[1] = pkt_seg(TOK_INITIAL, cfg_i.init_params);
                    phase_d   = PH_INITREP;
                  end
                end
                PH_INITREP: begin
                  if (hdr_q[0] == TOK_ACK && hdr_q[1] == TOK_INITIAL) begin
                    op.seg[0] = one_seg(KIND_BAUD, 8'h00, ST_OK);
                    op.seg[1] = pkt_seg(TOK_QUALITY, {cfg_i.quality, 24'h0});
                    phase_d   = PH_QUALREP;
                  end else begin
                    op.seg[0] = one_seg(KIND_DONE, 8'h00, ST_INIT_REJ);
                    phase_d   = PH_IDLE;
                  end
                end
                PH_QUALREP: begin
                  if (hdr_q[0] == TOK_ACK && hdr_q[1] == TOK_QUALITY) begin
                    op.seg[0] = pkt_seg(TOK_GET_PIC, {cfg_i.picture, 24'h0});
                    phase_d   = PH_PICREP;
                  end else begin
                    op.seg[0] = one_seg(KIND_DONE, 8'h00, ST_QUALITY_REJ);
                    phase_d   = PH_IDLE;
                  end
                end
                PH_PICREP: begin
                  if (hdr_q[0] == TOK_ACK && hdr_q[1] == TOK_GET_PIC) begin
                    phase_d = PH_DATAHDR;
                  end else begin
                    op.seg[0] = one_seg(KIND_DONE, 8'h00, ST_PICTURE_REJ);
                    phase_d   = PH_IDLE;
                  end
                end
                PH_DATAHDR: begin
                  if (hdr_q[0] != TOK_DATA) begin
                    op.seg[0] = one_seg(KIND_DONE, 8'h00, ST_NO_DATA);
                    phase_d   = PH_IDLE;
                  end else begin
                    rem_d  = {rx_byte_i, hdr_q[3], hdr_q[2]};
                    idle_d = 16'd0;
                    if ({rx_byte_i, hdr_q[3], hdr_q[2]} == 24'd0) begin
                      op.seg[0] = one_seg(KIND_DONE, 8'h00, ST_OK);
                      phase_d   = PH_IDLE;
                    end else begin
                      phase_d = PH_IMAGE;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ACT_TICK: begin
          if (phase_q == PH_RETRY) begin
            wait_d = wait_dec;
            if (wait_dec == 16'd0) begin
              op.seg[0] = pkt_seg(TOK_SYNC, 32'h0);
              idx_d     = 3'd0;
              phase_d   = PH_SYNCREP;
            end
          end else if (phase_q == PH_IMAGE) begin
            if (idle_q >= cfg_i.idle_limit) begin
              op.seg[0] = one_seg(KIND_DONE, 8'h00, ST_TIMEOUT);
              phase_d   = PH_IDLE;
              idx_d     = 3'd0;
            end else begin
              idle_d = idle_q + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push_o = op.seg[0].valid;
  assign op_o   = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= 3'd0;
      rem_q   <= 24'd0;
      idle_q  <= 16'd0;
      wait_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      rem_q   <= rem_d;
      idle_q  <= idle_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_ptr] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csps_queue.sv =====
// Command FIFO between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module csps_queue import csps_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  input  logic pop_i,
  output op_t  op_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  op_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csps_back.sv =====
// Back end: expands queued commands into one result per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module csps_back import csps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  op_i,
  input  logic q_empty_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic       seg_sel_q;
  logic [2:0] byte_sel_q;
  logic       out_valid_q;
  res_t       res_q;
  seg_t       seg;
  logic       advance, take, last_byte, last_seg;

  assign seg       = op_i.seg[seg_sel_q];
  assign advance   = !out_valid_q || out_ready_i;
  assign take      = advance && !q_empty_i;
  assign last_byte = !seg.is_pkt || (byte_sel_q == 3'd7);
  assign last_seg  = seg_sel_q || !op_i.seg[1].valid;
  assign pop_o     = take && last_byte && last_seg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_sel_q   <= 1'b0;
      byte_sel_q  <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        if (last_byte) begin
          byte_sel_q <= 3'd0;
          seg_sel_q  <= last_seg ? 1'b0 : 1'b1;
        end else begin
          byte_sel_q <= byte_sel_q + 3'd1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.kind       <= seg.kind;
      res_q.byte_value <= seg_byte(seg, byte_sel_q);
      res_q.status     <= seg.status;
      res_q.last       <= last_byte && last_seg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/csps_checker.sv =====
// Port-level assertions for the snapshot sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csps_checker import csps_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [7:0] out_byte_i,
  input logic [2:0] out_status_i,
  input logic       out_last_i
);

  // A stalled result is not withdrawn
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // Baud requests and finish markers carry no byte
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_BAUD || out_kind_i == KIND_DONE)
      |-> out_byte_i == 8'h00)
    else $error("byte value on baud or finish result");

  // Status is only reported on a finish marker
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_DONE |-> out_status_i == ST_OK)
    else $error("status on non-finish result");

  // A finish marker always closes the results of its transaction
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_DONE |-> out_last_i)
    else $error("finish marker without last");

endmodule

bind camera_snapshot_protocol_sequencer csps_checker u_csps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_kind_i   (result_o.kind),
  .out_byte_i   (result_o.byte_value),
  .out_status_i (result_o.status),
  .out_last_i   (result_o.last)
);

`default_nettype wire
